// File: src/geodetic_to_ecef_macros.svh
// ----------------------------------------------------------------------------
// geodetic_to_ecef_macros
// Assertion macros used by the checker of the geodetic to ECEF block.
// ----------------------------------------------------------------------------
`ifndef GEODETIC_TO_ECEF_MACROS_SVH
`define GEODETIC_TO_ECEF_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define G2E_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle rule");

// Consequent must hold in the same cycle as the antecedent.
`define G2E_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle rule");

// Consequent must hold in the cycle after reset is seen.
`define G2E_ASSERT_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) (reset) |=> (cons)) \
      else $error("assertion failed: reset rule");

`endif

// File: src/g2e_pkg.sv
// ----------------------------------------------------------------------------
// g2e_pkg
// Constants and elaboration-time constant builders for the geodetic
// to ECEF converter.
// ----------------------------------------------------------------------------
package g2e_pkg;

   localparam int CORDIC_STEPS_DEF = 32;
   localparam int INV_ROOT_ITERS   = 6;
   localparam int MUL_LATENCY      = 4;

   localparam int UPM_W     = 20;
   localparam int LIMIT_W   = 39;
   localparam int OUT_W     = 40;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 39;

   localparam logic [CSR_IDX_W-1:0] CSR_UNITS_PER_METRE  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COORDINATE_LIMIT = 4'd1;

   localparam logic [UPM_W-1:0]   UPM_RESET   = 20'd10000;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 39'h1F_FFFF_FFFF;

   localparam logic signed [31:0] LAT_MAX = 32'sd900000000;
   localparam logic signed [31:0] LON_MAX = 32'sd1800000000;

   localparam logic [63:0] Q60_ONE      = 64'h1000_0000_0000_0000;
   localparam logic [63:0] Q60_THREE    = 64'h3000_0000_0000_0000;
   localparam logic [63:0] SEMI_MAJOR_M = 64'd6378137;
   localparam logic [63:0] FLAT_DEN     = 64'd298257223563;
   localparam logic [63:0] GAIN_SEED    = 64'h09B7_4EDA_8435_E5A0;

   localparam logic [63:0] OUT_MAX_POS = 64'h0000_007F_FFFF_FFFF;
   localparam logic [63:0] OUT_MIN_MAG = 64'h0000_0080_0000_0000;
   localparam logic [OUT_W-1:0] OUT_SAT_POS = 40'h7F_FFFF_FFFF;
   localparam logic [OUT_W-1:0] OUT_SAT_NEG = 40'h80_0000_0000;

   // Height in Q40 is hm * 2^40 / 1000 rounded, split as hm * floor(2^37/125)
   // plus a short quotient by 125 done with a reciprocal and a correction.
   localparam int            H_BASE_W   = 59;
   localparam int            H_X_W      = 35;
   localparam int            H_Q_W      = 29;
   localparam logic [30:0]   H_BASE_MUL = 31'd1099511627;
   localparam logic [6:0]    H_REM_MUL  = 7'd97;
   localparam logic [6:0]    H_HALF     = 7'd62;
   localparam logic [6:0]    H_DIV      = 7'd125;
   localparam logic [63:0]   H_RECIP    = 64'd35184372088;
   localparam int            H_RECIP_SH = 42;

   function automatic logic [63:0] f_umul(input logic [63:0] a, input logic [63:0] b,
                                          input int sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << (sh - 1));
      return p[sh +: 64];
   endfunction

   function automatic logic [63:0] f_mag(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [63:0] f_smul(input logic [63:0] a, input logic [63:0] b,
                                          input int sh);
      logic [63:0] q;
      q = f_umul(f_mag(a), f_mag(b), sh);
      return (a[63] ^ b[63]) ? (64'd0 - q) : q;
   endfunction

   function automatic logic [63:0] f_inv_root(input logic [63:0] v, input logic [63:0] y0);
      logic [63:0] y;
      logic [63:0] t;
      y = y0;
      for (int i = 0; i < INV_ROOT_ITERS; i++) begin
         t = Q60_THREE - f_smul(v, f_smul(y, y, 60), 60);
         t = f_smul(y, t, 60);
         y = {t[63], t[63:1]};
      end
      return y;
   endfunction

   // Restoring long division, floor(num / den) for a nonzero den.
   function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // floor(num * 2^bits / den), kept to 64 bits.
   function automatic logic [63:0] f_udiv_shift(input logic [63:0] num,
                                                input logic [63:0] den, input int bits);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         q = q << 1;
         if (r >= {1'b0, den}) begin
            q = q | 64'd1;
            r = r - {1'b0, den};
         end
      end
      for (int i = 0; i < bits; i++) begin
         r = {r[63:0], 1'b0};
         q = q << 1;
         if (r >= {1'b0, den}) begin
            q = q | 64'd1;
            r = r - {1'b0, den};
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] f_atan_inv(input logic [63:0] n);
      logic [63:0] t;
      logic [63:0] s;
      t = f_udiv(64'd1 << 62, n);
      s = t;
      for (int k = 1; k < 64; k++) begin
         t = f_udiv(t, n * n);
         if ((k & 1) == 1) s = s - f_udiv(t, 64'(2 * k + 1));
         else              s = s + f_udiv(t, 64'(2 * k + 1));
      end
      return s;
   endfunction

   function automatic logic [63:0] f_pi_q62();
      return (64'd16 * f_atan_inv(64'd5)) - (64'd4 * f_atan_inv(64'd239));
   endfunction

   function automatic logic [63:0] f_atan_entry(input int i);
      logic [63:0] t;
      logic [63:0] s;
      if (i == 0) begin
         s = (f_pi_q62() + 64'd8) >> 4;
      end else begin
         t = 64'd1 << (62 - i);
         s = t;
         for (int k = 1; k < 64; k++) begin
            t = (2 * i >= 64) ? 64'd0 : (t >> (2 * i));
            if ((k & 1) == 1) s = s - f_udiv(t, 64'(2 * k + 1));
            else              s = s + f_udiv(t, 64'(2 * k + 1));
         end
         s = (s + 64'd2) >> 2;
      end
      return s;
   endfunction

   function automatic logic [63:0] f_gain(input int steps);
      logic [63:0] p;
      p = Q60_ONE;
      for (int i = 0; i < steps; i++) begin
         if (2 * i < 64) p = p + (p >> (2 * i));
      end
      return f_inv_root(p, GAIN_SEED);
   endfunction

   function automatic logic [63:0] f_e2_q60();
      logic [63:0] f;
      f = f_udiv_shift(64'd1000000000, FLAT_DEN, 62);
      return (f_umul(f, (64'd1 << 63) - f, 62) + 64'd2) >> 2;
   endfunction

   localparam logic [63:0] RAD_Q92 = f_udiv_shift(f_pi_q62(), 64'd1800000000, 30);
   localparam logic [63:0] E2_Q60  = f_e2_q60();
   localparam logic [63:0] OME_Q60 = Q60_ONE - E2_Q60;

endpackage

// File: src/geodetic_to_ecef.sv
// ----------------------------------------------------------------------------
// geodetic_to_ecef
// WGS84 geodetic position to scaled earth-centered earth-fixed coordinates.
// ----------------------------------------------------------------------------
// The block takes one position beat per clock while req_stall is low and
// returns one result beat per position, in order. A request beat reaches its
// response beat through the chain of dependent products: the angle scaling,
// the CORDIC stages, the six Newton steps of the inverse square root (three
// four-stage multipliers each) and the final radius, rotation and unit
// scaling products. Throughput is one beat per cycle whenever the response
// side takes beats. A two-entry output buffer lets the pipeline keep moving
// after the response side stalls until its skid entry fills; the request
// side is stalled only once that buffer is full. Angles outside +-90 degrees
// of latitude or +-180 degrees of longitude give zero coordinates with ok
// low. A coordinate whose scaled magnitude exceeds coordinate_limit is still
// delivered, with ok low, and coordinates that overflow 40 bits saturate.
// The registers are written through the csr port, which is always ready,
// and must only be changed while no position is in flight.
module geodetic_to_ecef #(
   parameter int CORDIC_STEPS = g2e_pkg::CORDIC_STEPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [31:0]             req_latitude,
   input  logic signed [31:0]             req_longitude,
   input  logic signed [27:0]             req_height,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [g2e_pkg::OUT_W-1:0] rsp_ecef_x,
   output logic signed [g2e_pkg::OUT_W-1:0] rsp_ecef_y,
   output logic signed [g2e_pkg::OUT_W-1:0] rsp_ecef_z,
   output logic                           rsp_ok,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [g2e_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [g2e_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import g2e_pkg::*;

   // Pipeline timing, counted in register stages after the input stage.
   localparam int T_P   = CORDIC_STEPS + 5;              // trig values ready
   localparam int T_V0  = T_P + 9;                       // 1 - e2 sin^2 ready
   localparam int T_INV = T_V0 + 13 * INV_ROOT_ITERS;    // inverse root ready
   localparam int T_N   = T_INV + MUL_LATENCY;           // prime vertical radius
   localparam int T_H   = 8;                             // height in Q40 ready
   localparam int T_END = T_N + 14;                      // last pipeline stage
   localparam int D_V   = T_END - 1;
   localparam int D_TRG = T_N + 5 - T_P;
   localparam int D_HQ  = T_N - 4;

   typedef struct packed {
      logic aok;
      logic flip;
   } ctl_type;

   typedef struct packed {
      logic [63:0] sl;
      logic [63:0] cl;
      logic [63:0] so;
      logic [63:0] co;
   } trig_type;

   typedef struct packed {
      logic [H_BASE_W-1:0] base;
      logic [H_X_W-1:0]    x;
      logic                neg;
   } hgt_type;

   typedef struct packed {
      logic [OUT_W-1:0] v;
      logic             over;
   } fin_type;

   function automatic fin_type finish_coord(input logic [63:0] v,
                                            input logic [LIMIT_W-1:0] limit);
      fin_type     r;
      logic [63:0] a;
      a = v[63] ? (64'd0 - v) : v;
      r.over = a > {{(64-LIMIT_W){1'b0}}, limit};
      if (v[63]) r.v = (a > OUT_MIN_MAG) ? OUT_SAT_NEG : v[OUT_W-1:0];
      else       r.v = (v > OUT_MAX_POS) ? OUT_SAT_POS : v[OUT_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [UPM_W-1:0]   upm_ff;
   logic [LIMIT_W-1:0] limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upm_ff   <= UPM_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_UNITS_PER_METRE:  upm_ff   <= csr_wdata[UPM_W-1:0];
            CSR_COORDINATE_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Flow control. The whole pipeline advances together; it only halts
   // while the output buffer holds a second result.
   // ---------------------------------------------------------------------
   logic en;
   logic skid_vld_ff;
   logic rsp_vld_ff;

   assign en        = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   // ---------------------------------------------------------------------
   // Input stage: range check and longitude fold into +-90 degrees.
   // ---------------------------------------------------------------------
   logic               s0_vld_ff;
   logic signed [31:0] lat_s0_ff, lon_s0_ff, lon_in;
   logic signed [27:0] h_s0_ff;
   ctl_type            ctl_s0_ff, ctl_in;

   always_comb begin
      ctl_in.aok = (req_latitude >= -LAT_MAX) && (req_latitude <= LAT_MAX) &&
                   (req_longitude >= -LON_MAX) && (req_longitude <= LON_MAX);
      priority if (req_longitude > LAT_MAX) begin
         lon_in      = req_longitude - LON_MAX;
         ctl_in.flip = 1'b1;
      end else if (req_longitude < -LAT_MAX) begin
         lon_in      = req_longitude + LON_MAX;
         ctl_in.flip = 1'b1;
      end else begin
         lon_in      = req_longitude;
         ctl_in.flip = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s0_vld_ff <= 1'b0;
      else if (en) s0_vld_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lat_s0_ff <= req_latitude;
         lon_s0_ff <= lon_in;
         h_s0_ff   <= req_height;
         ctl_s0_ff <= ctl_in;
      end
   end

   // Valid bits and per-item control travel alongside the data.
   logic    vld_ff [D_V];
   ctl_type ctl_d_ff [D_V];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < D_V; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= s0_vld_ff;
         for (int k = 1; k < D_V; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_d_ff[0] <= ctl_s0_ff;
         for (int k = 1; k < D_V; k++) ctl_d_ff[k] <= ctl_d_ff[k-1];
      end
   end

   // ---------------------------------------------------------------------
   // Angles to radians, then sine and cosine of both.
   // ---------------------------------------------------------------------
   logic [63:0] rad_lat, rad_lon;
   logic [63:0] sin_lat, cos_lat, sin_lon, cos_lon;

   g2e_mul #(.SHIFT(32)) u_rad_lat (
      .clock, .en,
      .mul_a({{32{lat_s0_ff[31]}}, lat_s0_ff}), .mul_b(RAD_Q92), .mul_p(rad_lat)
   );
   g2e_mul #(.SHIFT(32)) u_rad_lon (
      .clock, .en,
      .mul_a({{32{lon_s0_ff[31]}}, lon_s0_ff}), .mul_b(RAD_Q92), .mul_p(rad_lon)
   );

   g2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_lat (
      .clock, .en, .angle(rad_lat), .sine(sin_lat), .cosine(cos_lat)
   );
   g2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_lon (
      .clock, .en, .angle(rad_lon), .sine(sin_lon), .cosine(cos_lon)
   );

   // A folded longitude negates its sine and cosine.
   trig_type trig_ff;
   trig_type trig_d_ff [D_TRG];

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff.sl <= sin_lat;
         trig_ff.cl <= cos_lat;
         trig_ff.so <= ctl_d_ff[T_P-2].flip ? (64'd0 - sin_lon) : sin_lon;
         trig_ff.co <= ctl_d_ff[T_P-2].flip ? (64'd0 - cos_lon) : cos_lon;
         trig_d_ff[0] <= trig_ff;
         for (int k = 1; k < D_TRG; k++) trig_d_ff[k] <= trig_d_ff[k-1];
      end
   end

   // ---------------------------------------------------------------------
   // Height in millimeters to Q40 meters, rounded to nearest.
   // ---------------------------------------------------------------------
   logic [27:0]      hm_ff;
   logic             hneg_ff;
   hgt_type          hgt_ff;
   hgt_type          hgt_d_ff [4];
   logic [63:0]      hq0_w;
   logic [35:0]      hprod_w;
   logic [H_Q_W-1:0] hq_w;
   logic [63:0]      hqa_ff;
   logic             hneg7_ff;
   logic [63:0]      hq_ff;
   logic [63:0]      hq_d_ff [D_HQ];

   always_ff @(posedge clock) begin
      if (en) begin
         hm_ff   <= h_s0_ff[27] ? (28'd0 - h_s0_ff) : h_s0_ff;
         hneg_ff <= h_s0_ff[27];
         hgt_ff.base <= H_BASE_W'(hm_ff * H_BASE_MUL);
         hgt_ff.x    <= H_X_W'(hm_ff * H_REM_MUL) + H_X_W'(H_HALF);
         hgt_ff.neg  <= hneg_ff;
         hgt_d_ff[0] <= hgt_ff;
         for (int k = 1; k < 4; k++) hgt_d_ff[k] <= hgt_d_ff[k-1];
      end
   end

   g2e_mul #(.SHIFT(H_RECIP_SH)) u_hdiv (
      .clock, .en,
      .mul_a({{(64-H_X_W){1'b0}}, hgt_ff.x}), .mul_b(H_RECIP), .mul_p(hq0_w)
   );

   // The reciprocal estimate is within one of the quotient; fix it here.
   assign hprod_w = 36'(hq0_w[H_Q_W-1:0]) * 36'(H_DIV);

   always_comb begin
      priority if (hprod_w > {1'b0, hgt_d_ff[3].x}) begin
         hq_w = hq0_w[H_Q_W-1:0] - H_Q_W'(1);
      end else if (({1'b0, hgt_d_ff[3].x} - hprod_w) >= 36'(H_DIV)) begin
         hq_w = hq0_w[H_Q_W-1:0] + H_Q_W'(1);
      end else begin
         hq_w = hq0_w[H_Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hqa_ff   <= {{(64-H_BASE_W){1'b0}}, hgt_d_ff[3].base}
                     + {{(64-H_Q_W){1'b0}}, hq_w};
         hneg7_ff <= hgt_d_ff[3].neg;
         hq_ff    <= hneg7_ff ? (64'd0 - hqa_ff) : hqa_ff;
         hq_d_ff[0] <= hq_ff;
         for (int k = 1; k < D_HQ; k++) hq_d_ff[k] <= hq_d_ff[k-1];
      end
   end

   // ---------------------------------------------------------------------
   // w = 1 - e2 sin^2(lat), then Newton steps toward 1 / sqrt(w).
   // ---------------------------------------------------------------------
   logic [63:0] ssq_w, esq_w, w_ff;
   logic [63:0] iy [INV_ROOT_ITERS+1];
   logic [63:0] iv [INV_ROOT_ITERS];

   g2e_mul #(.SHIFT(60)) u_ssq (
      .clock, .en, .mul_a(trig_ff.sl), .mul_b(trig_ff.sl), .mul_p(ssq_w)
   );
   g2e_mul #(.SHIFT(60)) u_esq (
      .clock, .en, .mul_a(E2_Q60), .mul_b(ssq_w), .mul_p(esq_w)
   );

   always_ff @(posedge clock) begin
      if (en) w_ff <= Q60_ONE - esq_w;
   end

   assign iy[0] = Q60_ONE;
   assign iv[0] = w_ff;

   for (genvar k = 0; k < INV_ROOT_ITERS; k++) begin : g_newton
      logic [63:0] yd_ff [9];
      logic [63:0] vd_ff [13];
      logic [63:0] a_w, b_w, c_w, t_ff;

      g2e_mul #(.SHIFT(60)) u_yy (
         .clock, .en, .mul_a(iy[k]), .mul_b(iy[k]), .mul_p(a_w)
      );
      g2e_mul #(.SHIFT(60)) u_vyy (
         .clock, .en, .mul_a(vd_ff[3]), .mul_b(a_w), .mul_p(b_w)
      );
      g2e_mul #(.SHIFT(60)) u_yt (
         .clock, .en, .mul_a(yd_ff[8]), .mul_b(t_ff), .mul_p(c_w)
      );

      always_ff @(posedge clock) begin
         if (en) begin
            yd_ff[0] <= iy[k];
            for (int j = 1; j < 9; j++) yd_ff[j] <= yd_ff[j-1];
            vd_ff[0] <= iv[k];
            for (int j = 1; j < 13; j++) vd_ff[j] <= vd_ff[j-1];
            t_ff <= Q60_THREE - b_w;
         end
      end

      assign iy[k+1] = {c_w[63], c_w[63:1]};
      if (k < INV_ROOT_ITERS - 1) begin : g_pass
         assign iv[k+1] = vd_ff[12];
      end
   end

   // ---------------------------------------------------------------------
   // Radii, rotation onto the axes and scaling to output units.
   // ---------------------------------------------------------------------
   logic [63:0] n_w, nome_w, rn_ff, rz_ff, p1_w;
   logic [63:0] mx_w, my_w, mz_w, sx_w, sy_w, sz_w;
   logic [63:0] upm_w;

   assign upm_w = {{(64-UPM_W){1'b0}}, upm_ff};

   g2e_mul #(.SHIFT(20)) u_n (
      .clock, .en, .mul_a(SEMI_MAJOR_M), .mul_b(iy[INV_ROOT_ITERS]), .mul_p(n_w)
   );
   g2e_mul #(.SHIFT(60)) u_nome (
      .clock, .en, .mul_a(n_w), .mul_b(OME_Q60), .mul_p(nome_w)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         rn_ff <= n_w + hq_d_ff[T_N-9];
         rz_ff <= nome_w + hq_d_ff[T_N-5];
      end
   end

   g2e_mul #(.SHIFT(60)) u_p1 (
      .clock, .en, .mul_a(rn_ff), .mul_b(trig_d_ff[T_N-T_P].cl), .mul_p(p1_w)
   );
   g2e_mul #(.SHIFT(60)) u_mx (
      .clock, .en, .mul_a(p1_w), .mul_b(trig_d_ff[D_TRG-1].co), .mul_p(mx_w)
   );
   g2e_mul #(.SHIFT(60)) u_my (
      .clock, .en, .mul_a(p1_w), .mul_b(trig_d_ff[D_TRG-1].so), .mul_p(my_w)
   );
   g2e_mul #(.SHIFT(60)) u_mz (
      .clock, .en, .mul_a(rz_ff), .mul_b(trig_d_ff[D_TRG-1].sl), .mul_p(mz_w)
   );
   g2e_mul #(.SHIFT(40)) u_sx (
      .clock, .en, .mul_a(mx_w), .mul_b(upm_w), .mul_p(sx_w)
   );
   g2e_mul #(.SHIFT(40)) u_sy (
      .clock, .en, .mul_a(my_w), .mul_b(upm_w), .mul_p(sy_w)
   );
   g2e_mul #(.SHIFT(40)) u_sz (
      .clock, .en, .mul_a(mz_w), .mul_b(upm_w), .mul_p(sz_w)
   );

   // ---------------------------------------------------------------------
   // Limit check, saturation and the angle-range override.
   // ---------------------------------------------------------------------
   fin_type          fx_w, fy_w, fz_w;
   logic             aok_w;
   logic             lst_vld_ff;
   logic [OUT_W-1:0] lst_x_ff, lst_y_ff, lst_z_ff;
   logic             lst_ok_ff;

   assign fx_w  = finish_coord(sx_w, limit_ff);
   assign fy_w  = finish_coord(sy_w, limit_ff);
   assign fz_w  = finish_coord(sz_w, limit_ff);
   assign aok_w = ctl_d_ff[D_V-1].aok;

   always_ff @(posedge clock) begin
      if (reset) lst_vld_ff <= 1'b0;
      else if (en) lst_vld_ff <= vld_ff[D_V-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lst_x_ff  <= aok_w ? fx_w.v : '0;
         lst_y_ff  <= aok_w ? fy_w.v : '0;
         lst_z_ff  <= aok_w ? fz_w.v : '0;
         lst_ok_ff <= aok_w && !fx_w.over && !fy_w.over && !fz_w.over;
      end
   end

   // ---------------------------------------------------------------------
   // Output register with one skid entry behind it.
   // ---------------------------------------------------------------------
   logic             out_free;
   logic [OUT_W-1:0] out_x_ff, out_y_ff, out_z_ff, skd_x_ff, skd_y_ff, skd_z_ff;
   logic             out_ok_ff, skd_ok_ff;

   assign out_free = !rsp_vld_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (out_free) begin
            rsp_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (lst_vld_ff) begin
         if (out_free) rsp_vld_ff <= 1'b1;
         else          skid_vld_ff <= 1'b1;
      end else if (out_free) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (out_free) begin
            out_x_ff  <= skd_x_ff;
            out_y_ff  <= skd_y_ff;
            out_z_ff  <= skd_z_ff;
            out_ok_ff <= skd_ok_ff;
         end
      end else if (lst_vld_ff) begin
         if (out_free) begin
            out_x_ff  <= lst_x_ff;
            out_y_ff  <= lst_y_ff;
            out_z_ff  <= lst_z_ff;
            out_ok_ff <= lst_ok_ff;
         end else begin
            skd_x_ff  <= lst_x_ff;
            skd_y_ff  <= lst_y_ff;
            skd_z_ff  <= lst_z_ff;
            skd_ok_ff <= lst_ok_ff;
         end
      end
   end

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_ecef_x = $signed(out_x_ff);
   assign rsp_ecef_y = $signed(out_y_ff);
   assign rsp_ecef_z = $signed(out_z_ff);
   assign rsp_ok     = out_ok_ff;
endmodule

// File: src/g2e_mul.sv
// ----------------------------------------------------------------------------
// g2e_mul
// Four-stage signed 64 x 64 multiplier with a rounded right shift, built from
// 32 x 32 partial products; rounds half away from zero.
// ----------------------------------------------------------------------------
module g2e_mul #(
   parameter int SHIFT = 60
) (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] mul_a,
   input  logic [63:0] mul_b,
   output logic [63:0] mul_p
);
   localparam logic [127:0] ROUND = 128'd1 << (SHIFT - 1);

   logic [63:0]  ma_ff, mb_ff;
   logic [2:0]   neg_ff;
   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [63:0]  p00_in, p01_in, p10_in, p11_in;
   logic [127:0] sum_ff, sum_in;
   logic [63:0]  q_w;
   logic [63:0]  p_ff;

   assign p00_in = ma_ff[31:0]  * mb_ff[31:0];
   assign p01_in = ma_ff[31:0]  * mb_ff[63:32];
   assign p10_in = ma_ff[63:32] * mb_ff[31:0];
   assign p11_in = ma_ff[63:32] * mb_ff[63:32];
   assign sum_in = {p11_ff, p00_ff} + {32'd0, p01_ff, 32'd0} + {32'd0, p10_ff, 32'd0}
                   + ROUND;
   assign q_w    = sum_ff[SHIFT +: 64];

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff  <= mul_a[63] ? (64'd0 - mul_a) : mul_a;
         mb_ff  <= mul_b[63] ? (64'd0 - mul_b) : mul_b;
         neg_ff <= {neg_ff[1:0], mul_a[63] ^ mul_b[63]};
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
         sum_ff <= sum_in;
         p_ff   <= neg_ff[2] ? (64'd0 - q_w) : q_w;
      end
   end

   assign mul_p = p_ff;
endmodule

// File: src/g2e_cordic.sv
// ----------------------------------------------------------------------------
// g2e_cordic
// Rotation-mode CORDIC, one registered micro-rotation per stage, giving sine
// and cosine in Q60 of a Q60 angle in radians.
// ----------------------------------------------------------------------------
module g2e_cordic #(
   parameter int STEPS = g2e_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] angle,
   output logic [63:0] sine,
   output logic [63:0] cosine
);
   import g2e_pkg::*;

   localparam logic [63:0] GAIN = f_gain(STEPS);

   logic [63:0] x_ff [STEPS];
   logic [63:0] y_ff [STEPS];
   logic [63:0] z_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic [63:0] ATAN_I = f_atan_entry(i);
      logic [63:0] xs, ys, zs, dx, dy;
      if (i == 0) begin : g_first
         assign xs = GAIN;
         assign ys = 64'd0;
         assign zs = angle;
      end else begin : g_next
         assign xs = x_ff[i-1];
         assign ys = y_ff[i-1];
         assign zs = z_ff[i-1];
      end
      assign dx = $signed(ys) >>> i;
      assign dy = $signed(xs) >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            if (zs[63]) begin
               x_ff[i] <= xs + dx;
               y_ff[i] <= ys - dy;
               z_ff[i] <= zs + ATAN_I;
            end else begin
               x_ff[i] <= xs - dx;
               y_ff[i] <= ys + dy;
               z_ff[i] <= zs - ATAN_I;
            end
         end
      end
   end

   assign sine   = y_ff[STEPS-1];
   assign cosine = x_ff[STEPS-1];
endmodule

// File: src/g2e_checker.sv
// ----------------------------------------------------------------------------
// g2e_checker
// Port-level assertions for the geodetic to ECEF block, bound to its top.
// ----------------------------------------------------------------------------
`include "geodetic_to_ecef_macros.svh"

module g2e_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic signed [g2e_pkg::OUT_W-1:0] rsp_ecef_x,
   input logic signed [g2e_pkg::OUT_W-1:0] rsp_ecef_y,
   input logic signed [g2e_pkg::OUT_W-1:0] rsp_ecef_z,
   input logic                             rsp_ok
);
   logic rail_w;

   assign rail_w = rsp_valid && (rsp_ecef_x == 40'sh80_0000_0000 ||
                                 rsp_ecef_y == 40'sh80_0000_0000 ||
                                 rsp_ecef_z == 40'sh80_0000_0000);

   // A stalled response beat stays offered.
   `G2E_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // The request side is only stalled after the response side refused a beat.
   `G2E_ASSERT_SAME(a_stall_cause, req_stall, $past(rsp_valid && rsp_stall))

   // A coordinate at the negative rail is always beyond any legal limit.
   `G2E_ASSERT_SAME(a_rail_flag, rail_w, !rsp_ok)

   // Reset empties the output and releases the request side.
   `G2E_ASSERT_RESET(a_reset_clear, !rsp_valid && !req_stall)
endmodule

bind geodetic_to_ecef g2e_checker u_g2e_checker (.*);

// File: verif/tb_geodetic_to_ecef.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_geodetic_to_ecef
// Self-checking bench for the geodetic to ECEF converter. A bit-exact
// fixed-point predictor computes each expected coordinate beat as a position
// beat is accepted, and a scoreboard compares response beats in order.
// Directed corners are followed by random phases under several register
// settings, with random idling on the request side and random stalls on the
// response side.
// ----------------------------------------------------------------------------
module tb_geodetic_to_ecef;
   import g2e_pkg::*;

   typedef logic [63:0] word_type;

   // One expected response beat.
   typedef struct {
      logic [39:0] x;
      logic [39:0] y;
      logic [39:0] z;
      logic        ok;
   } ecef_type;

   localparam int       STEPS      = 32;
   localparam int       NEWTON     = 6;
   localparam word_type ONE_Q60    = 64'h1000_0000_0000_0000;
   localparam word_type SAT_MAX    = (64'd1 << 39) - 1;
   localparam int       SETTLE     = 160;
   localparam int       CYCLE_LIMIT = 400000;

   // The scoreboard holds its own copy of the registers and the constant
   // tables, predicts a response for every accepted position beat and checks
   // response beats against the oldest prediction.
   class position_board;
      word_type atan_q60[STEPS];
      word_type gain_q60;
      word_type rad_q92;
      word_type e2;
      word_type one_less_e2;
      word_type scale;
      word_type limit;
      ecef_type pending[$];
      int       errors;
      int       seen;
      int       rejected;

      function new();
         word_type pi_q62, flat_q62, p, t, s;
         pi_q62 = 16 * series_inv(64'd5) - 4 * series_inv(64'd239);
         atan_q60[0] = (pi_q62 + 8) >> 4;
         for (int i = 1; i < STEPS; i++) begin
            t = word_type'(1) << (62 - i);
            s = t;
            for (int k = 1; k < 64; k++) begin
               t = (2 * i >= 64) ? 64'd0 : (t >> (2 * i));
               if (t == 0) break;
               if (k & 1) s = s - t / word_type'(2 * k + 1);
               else       s = s + t / word_type'(2 * k + 1);
            end
            atan_q60[i] = (s + 2) >> 2;
         end
         p = ONE_Q60;
         for (int i = 0; i < STEPS; i++) p = p + (p >> (2 * i));
         gain_q60 = rsqrt(p, 64'h09B7_4EDA_8435_E5A0);
         rad_q92 = long_div(pi_q62, 64'd1800000000, 30);
         flat_q62 = long_div(64'd1000000000, 64'd298257223563, 62);
         e2 = (urnd(flat_q62, (word_type'(1) << 63) - flat_q62, 62) + 2) >> 2;
         one_less_e2 = ONE_Q60 - e2;
         scale = 10000;
         limit = 64'd137438953471;
         errors = 0;
         seen = 0;
         rejected = 0;
      endfunction

      function word_type urnd(word_type a, word_type b, int sh);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, b} + (128'd1 << (sh - 1));
         return p[sh +: 64];
      endfunction

      function word_type absv(word_type v);
         return v[63] ? -v : v;
      endfunction

      // Signed product, rounded half away from zero.
      function word_type srnd(word_type a, word_type b, int sh);
         word_type q;
         q = urnd(absv(a), absv(b), sh);
         return (a[63] ^ b[63]) ? -q : q;
      endfunction

      function word_type long_div(word_type num, word_type den, int bits);
         word_type q, r;
         q = num / den;
         r = num % den;
         for (int i = 0; i < bits; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
               q = q | 1;
               r = r - den;
            end
         end
         return q;
      endfunction

      function word_type series_inv(word_type n);
         word_type t, s;
         t = (word_type'(1) << 62) / n;
         s = t;
         for (int k = 1; k < 64; k++) begin
            t = t / (n * n);
            if (t == 0) break;
            if (k & 1) s = s - t / word_type'(2 * k + 1);
            else       s = s + t / word_type'(2 * k + 1);
         end
         return s;
      endfunction

      function word_type rsqrt(word_type v, word_type y);
         word_type t;
         for (int i = 0; i < NEWTON; i++) begin
            t = 3 * ONE_Q60 - srnd(v, srnd(y, y, 60), 60);
            y = word_type'($signed(srnd(y, t, 60)) >>> 1);
         end
         return y;
      endfunction

      function word_type angle_rad(longint v);
         word_type m, r;
         m = (v < 0) ? word_type'(-v) : word_type'(v);
         r = urnd(m, rad_q92, 32);
         return (v < 0) ? -r : r;
      endfunction

      function void rotate(word_type z, output word_type sn, output word_type cs);
         word_type x, y, dx, dy;
         x = gain_q60;
         y = 0;
         for (int i = 0; i < STEPS; i++) begin
            dx = word_type'($signed(y) >>> i);
            dy = word_type'($signed(x) >>> i);
            if (z[63]) begin
               x = x + dx;
               y = y - dy;
               z = z + atan_q60[i];
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - atan_q60[i];
            end
         end
         sn = y;
         cs = x;
      endfunction

      // Scale metres to output units, judge the limit, then saturate.
      function logic [39:0] to_units(word_type m_q40, inout logic ok);
         word_type v, a;
         v = srnd(m_q40, scale, 40);
         a = absv(v);
         if (a > limit) ok = 1'b0;
         if (v[63]) begin
            if (a > SAT_MAX + 1) v = -(SAT_MAX + 1);
         end else if (v > SAT_MAX) begin
            v = SAT_MAX;
         end
         return v[39:0];
      endfunction

      function void write_reg(logic [3:0] idx, logic [38:0] data);
         if (idx == CSR_UNITS_PER_METRE) scale = word_type'(data[19:0]);
         else if (idx == CSR_COORDINATE_LIMIT) limit = word_type'(data);
      endfunction

      function void note(logic signed [31:0] lat_in, logic signed [31:0] lon_in,
                         logic signed [27:0] h_in);
         longint   lat, lon, h;
         word_type sl, cl, so, co, w, n, hm, hq, rn, rz;
         logic     flip, ok;
         ecef_type e;
         lat = lat_in;
         lon = lon_in;
         h = h_in;
         flip = 1'b0;
         ok = 1'b1;
         if (lat < -900000000 || lat > 900000000 ||
             lon < -1800000000 || lon > 1800000000) begin
            e = '{40'd0, 40'd0, 40'd0, 1'b0};
            rejected++;
         end else begin
            // Longitudes past a quarter turn are folded by half a turn.
            if (lon > 900000000) begin
               lon = lon - 1800000000;
               flip = 1'b1;
            end else if (lon < -900000000) begin
               lon = lon + 1800000000;
               flip = 1'b1;
            end
            rotate(angle_rad(lat), sl, cl);
            rotate(angle_rad(lon), so, co);
            if (flip) begin
               so = -so;
               co = -co;
            end
            w = ONE_Q60 - srnd(e2, srnd(sl, sl, 60), 60);
            n = srnd(64'd6378137, rsqrt(w, ONE_Q60), 20);
            hm = (h < 0) ? word_type'(-h) : word_type'(h);
            hq = ((hm / 1000) << 40) + ((((hm % 1000) << 40) + 500) / 1000);
            if (h < 0) hq = -hq;
            rn = n + hq;
            rz = srnd(n, one_less_e2, 60) + hq;
            e.x = to_units(srnd(srnd(rn, cl, 60), co, 60), ok);
            e.y = to_units(srnd(srnd(rn, cl, 60), so, 60), ok);
            e.z = to_units(srnd(rz, sl, 60), ok);
            e.ok = ok;
         end
         pending.push_back(e);
      endfunction

      task report(string what, logic [39:0] got, logic [39:0] want);
         $display("MISMATCH beat %0d %s: got %h expected %h", seen, what, got, want);
         errors++;
      endtask

      task check(logic [39:0] x, logic [39:0] y, logic [39:0] z, logic ok);
         ecef_type e;
         if (pending.size() == 0) begin
            report("unexpected response", x, 40'd0);
         end else begin
            e = pending.pop_front();
            if (x !== e.x) report("ecef_x", x, e.x);
            if (y !== e.y) report("ecef_y", y, e.y);
            if (z !== e.z) report("ecef_z", z, e.z);
            if (ok !== e.ok) report("ok", 40'(ok), 40'(e.ok));
         end
         seen++;
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic signed [31:0]  req_latitude;
   logic signed [31:0]  req_longitude;
   logic signed [27:0]  req_height;
   logic                rsp_valid;
   logic                rsp_stall;
   logic signed [39:0]  rsp_ecef_x;
   logic signed [39:0]  rsp_ecef_y;
   logic signed [39:0]  rsp_ecef_z;
   logic                rsp_ok;
   logic                csr_valid;
   logic                csr_ready;
   logic [3:0]          csr_index;
   logic [38:0]         csr_wdata;

   position_board board = new();
   bit            calm;
   int            cycles;
   int            sent;

   geodetic_to_ecef DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_latitude  (req_latitude),
      .req_longitude (req_longitude),
      .req_height    (req_height),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ecef_x    (rsp_ecef_x),
      .rsp_ecef_y    (rsp_ecef_y),
      .rsp_ecef_z    (rsp_ecef_z),
      .rsp_ok        (rsp_ok),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // The clock starts low so that the first rising edge comes after the
   // initial values are in place.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Both handshakes are sampled at the rising edge, where every input still
   // holds the value that the previous edge gave it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note(req_latitude, req_longitude, req_height);
         if (rsp_valid && !rsp_stall) board.check(rsp_ecef_x, rsp_ecef_y, rsp_ecef_z, rsp_ok);
      end
   end

   // The response side stalls at random with a 15 percent chance, unless calm.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 15);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Present one position beat and hold it until the block takes it. Valid
   // stays high from one beat into the next unless a random idle gap falls
   // in between.
   task send_position(logic signed [31:0] lat, logic signed [31:0] lon,
                      logic signed [27:0] h);
      if (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_latitude  <= lat;
      req_longitude <= lon;
      req_height    <= h;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // Stop sending, wait for every outstanding beat and let the pipeline
   // settle so that a register can be changed safely.
   task drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // One register write, after which the task idles the write channel before returning.
   task write_csr(logic [3:0] idx, logic [38:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random positions: mostly valid angles with realistic heights, some at
   // the range edges, and some raw 32 and 28 bit noise.
   task send_random(int count, int pause_at);
      int    sel;
      logic signed [31:0] lat, lon;
      logic signed [27:0] h;
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) begin
            // Hold off until the pipeline is empty, then carry on.
            req_valid <= 1'b0;
            do @(posedge clock); while (board.pending.size() != 0);
         end
         sel = $urandom_range(99);
         if (sel < 80) begin
            lat = $signed($urandom_range(1800000000)) - 900000000;
            lon = $signed($urandom_range(3600000000)) - 32'sd1800000000;
            h   = ($urandom_range(1)) ? 28'($signed($urandom_range(200000000)) - 100000000)
                                      : 28'($signed($urandom_range(20000000)) - 10000000);
         end else if (sel < 90) begin
            lat = ($urandom_range(1) ? 900000000 : -900000000) + $signed($urandom_range(4)) - 2;
            lon = ($urandom_range(1) ? 32'sd1800000000 : -32'sd1800000000)
                  + $signed($urandom_range(4)) - 2;
            if ($urandom_range(1)) lon = ($urandom_range(1) ? 900000000 : -900000000)
                                         + $signed($urandom_range(4)) - 2;
            h = 28'($urandom);
         end else begin
            lat = $urandom;
            lon = $urandom;
            h   = 28'($urandom);
         end
         send_position(lat, lon, h);
      end
   endtask

   initial begin
      calm          <= 1'b0;
      cycles        <= 0;
      sent          = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_latitude  <= '0;
      req_longitude <= '0;
      req_height    <= '0;
      rsp_stall     <= 1'b0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners at the reset settings: origin, poles, the angle
      // limits and one step past them, the half-turn fold of longitude, raw
      // extremes of every field and the height extremes.
      send_position(0, 0, 0);
      send_position(900000000, 0, 0);
      send_position(-900000000, 0, 0);
      send_position(900000001, 0, 0);
      send_position(-900000001, 0, 0);
      send_position(0, 1800000000, 0);
      send_position(0, -1800000000, 0);
      send_position(0, 1800000001, 0);
      send_position(0, -1800000001, 0);
      send_position(0, 900000000, 0);
      send_position(0, 900000001, 0);
      send_position(0, -900000000, 0);
      send_position(0, -900000001, 0);
      send_position(32'h8000_0000, 32'h8000_0000, 28'h800_0000);
      send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 28'h7FF_FFFF);
      send_position(450000000, 450000000, 100000000);
      send_position(-450000000, -1350000000, -100000000);
      send_position(123456789, -987654321, 28'h7FF_FFFF);
      send_position(-1, -1, -1);
      send_position(1, 1, 1);
      send_position(899999999, 1799999999, 28'h800_0000);
      drain();

      // Coarsest scale with a zero limit: ok only for all-zero coordinates.
      write_csr(CSR_UNITS_PER_METRE, 39'd1);
      write_csr(CSR_COORDINATE_LIMIT, 39'd0);
      send_random(150, -1);
      drain();

      // Finest scale: coordinates overflow 40 bits and saturate.
      write_csr(CSR_UNITS_PER_METRE, 39'd1000000);
      write_csr(CSR_COORDINATE_LIMIT, 39'h7F_FFFF_FFFF);
      send_position(0, 0, 28'h7FF_FFFF);
      send_position(0, 1800000000, 28'h7FF_FFFF);
      send_random(150, -1);
      drain();

      // Zero scale gives zero coordinates.
      write_csr(CSR_UNITS_PER_METRE, 39'd0);
      send_random(100, -1);
      drain();

      // Back to the reset settings; an index past the register list must be
      // ignored. The first part of this phase runs with no idling at all and
      // the sender later pauses until the pipeline has emptied.
      write_csr(4'd7, 39'h12_3456_789A);
      write_csr(CSR_UNITS_PER_METRE, 39'd10000);
      write_csr(CSR_COORDINATE_LIMIT, 39'd137438953471);
      calm <= 1'b1;
      send_random(200, -1);
      calm <= 1'b0;
      send_random(200, 100);
      drain();

      write_csr(CSR_UNITS_PER_METRE, 39'($urandom_range(1000000, 1)));
      write_csr(CSR_COORDINATE_LIMIT, {$urandom, 7'($urandom)});
      send_random(350, -1);
      drain();

      write_csr(CSR_UNITS_PER_METRE, 39'd1000);
      write_csr(CSR_COORDINATE_LIMIT, 39'h1_0000_0000);
      send_random(380, -1);
      drain();

      $display("Covered %0d positions (%0d with angles out of range) under seven register",
               sent, board.rejected);
      $display("settings, including zero and full scale, with random idling and stalls.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/g2e_pkg.sv
src/g2e_mul.sv
src/g2e_cordic.sv
src/geodetic_to_ecef.sv
src/g2e_checker.sv
verif/tb_geodetic_to_ecef.sv
